@@ hw/rtl/alt_pkg.sv @@
// Shared types and constants for the allocation tracker.
// No dependencies.
package alt_pkg;

    localparam int TableEntries  = 1024;
    localparam int CategoryCount = 12;
    localparam int AddressBits   = 48;
    localparam int BytesW        = 48;
    localparam int CountW        = 32;
    localparam int SizeW         = 32;
    localparam int CatW          = 4;

    localparam logic [1:0] StOk        = 2'd0;
    localparam logic [1:0] StNull      = 2'd1;
    localparam logic [1:0] StUntracked = 2'd2;
    localparam logic [1:0] StFull      = 2'd3;

    typedef struct packed {
        logic                   func;
        logic [AddressBits-1:0] address;
        logic [SizeW-1:0]       size_bytes;
        logic [CatW-1:0]        category;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        logic [CatW-1:0]   category_out;
        logic [BytesW-1:0] cat_live_bytes;
        logic [CountW-1:0] cat_live_count;
        logic [BytesW-1:0] cat_total_bytes;
        logic [BytesW-1:0] cat_peak_bytes;
        logic [BytesW-1:0] all_live_bytes;
        logic [CountW-1:0] all_live_count;
        logic [BytesW-1:0] all_total_bytes;
        logic [BytesW-1:0] all_peak_bytes;
        logic              no_leaks;
    } t_out_item;

    typedef struct packed {
        logic [BytesW-1:0] live_bytes;
        logic [CountW-1:0] live_count;
        logic [BytesW-1:0] total_bytes;
        logic [BytesW-1:0] peak_bytes;
    } t_stats;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_WAIT, S_STATRD, S_STATWR, S_FETCH, S_OUT
    } t_state;

    function automatic logic [BytesW-1:0] sat_add_b(logic [BytesW-1:0] a,
                                                    logic [SizeW-1:0] b);
        logic [BytesW:0] s;
        s = {1'b0, a} + {{(BytesW-SizeW+1){1'b0}}, b};
        return s[BytesW] ? {BytesW{1'b1}} : s[BytesW-1:0];
    endfunction

    function automatic logic [BytesW-1:0] flr_sub_b(logic [BytesW-1:0] a,
                                                    logic [SizeW-1:0] b);
        logic [BytesW-1:0] be;
        be = {{(BytesW-SizeW){1'b0}}, b};
        return (a > be) ? a - be : '0;
    endfunction

    function automatic t_stats stats_alloc(t_stats s, logic [SizeW-1:0] sz);
        t_stats r;
        r = s;
        r.live_bytes  = sat_add_b(s.live_bytes, sz);
        r.live_count  = (s.live_count == {CountW{1'b1}}) ? s.live_count
                                                         : s.live_count + 1'b1;
        r.total_bytes = sat_add_b(s.total_bytes, sz);
        if (r.live_bytes > s.peak_bytes) begin
            r.peak_bytes = r.live_bytes;
        end
        return r;
    endfunction

    function automatic t_stats stats_free(t_stats s, logic [SizeW-1:0] sz);
        t_stats r;
        r = s;
        r.live_bytes = flr_sub_b(s.live_bytes, sz);
        r.live_count = (s.live_count != '0) ? s.live_count - 1'b1 : '0;
        return r;
    endfunction

endpackage

@@ hw/rtl/alt_table.sv @@
// Record table: valid flag, address, size and category in one memory,
// emptied by a clearing pass over every entry after reset. Depends on alt_pkg.
module alt_table import alt_pkg::*; #(
    parameter int TABLE_ENTRIES = TableEntries,
    localparam int IdxW = $clog2(TABLE_ENTRIES)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    output logic                   o_ready,
    input  logic [IdxW-1:0]        i_rd_idx,
    output logic [AddressBits-1:0] o_rd_addr,
    output logic [SizeW-1:0]       o_rd_size,
    output logic [CatW-1:0]        o_rd_cat,
    output logic                   o_rd_valid,
    input  logic                   i_wr_en,
    input  logic [IdxW-1:0]        i_wr_idx,
    input  logic                   i_wr_valid,
    input  logic [AddressBits-1:0] i_wr_addr,
    input  logic [SizeW-1:0]       i_wr_size,
    input  logic [CatW-1:0]        i_wr_cat
);
    localparam int RecW = 1 + AddressBits + SizeW + CatW;

    logic [RecW-1:0] r_mem [TABLE_ENTRIES];
    logic [RecW-1:0] r_rd;
    logic            r_clearing;
    logic [IdxW-1:0] r_clr_idx;

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_idx] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_idx] <= {i_wr_valid, i_wr_addr, i_wr_size, i_wr_cat};
        end
        r_rd <= r_mem[i_rd_idx];
    end

    // Walk every entry once after reset to drop all records.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            if (r_clr_idx == IdxW'(TABLE_ENTRIES - 1)) begin
                r_clearing <= 1'b0;
            end else begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
        end
    end

    assign o_ready    = !r_clearing;
    assign o_rd_valid = r_rd[RecW-1];
    assign o_rd_addr  = r_rd[RecW-2 -: AddressBits];
    assign o_rd_size  = r_rd[CatW +: SizeW];
    assign o_rd_cat   = r_rd[CatW-1:0];
endmodule

@@ hw/rtl/alt_stats.sv @@
// Per-category statistics memory plus the grand-total registers.
// Depends on alt_pkg.
module alt_stats import alt_pkg::*; #(
    parameter int CATEGORY_COUNT = CategoryCount
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [CatW-1:0] i_rd_cat,
    output t_stats          o_rd_cat,
    output t_stats          o_sum,
    input  logic            i_wr_en,
    input  logic [CatW-1:0] i_wr_cat,
    input  t_stats          i_wr_cat_stats,
    input  t_stats          i_wr_sum
);
    t_stats r_mem [CATEGORY_COUNT];
    t_stats r_rd;
    t_stats r_sum;
    logic [CATEGORY_COUNT-1:0] r_init;
    logic r_rd_init;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_cat] <= i_wr_cat_stats;
        end
        r_rd <= r_mem[i_rd_cat];
    end

    // Entries never written read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init    <= '0;
            r_sum     <= '0;
            r_rd_init <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_init[i_wr_cat] <= 1'b1;
                r_sum            <= i_wr_sum;
            end
            r_rd_init <= r_init[i_rd_cat];
        end
    end

    assign o_rd_cat = r_rd_init ? r_rd : '0;
    assign o_sum    = r_sum;
endmodule

@@ hw/rtl/allocation_tracker_with_category_stats.sv @@
// Allocation tracker top level: sequencer over record table and statistics.
// Sequence: an accepted event starts a scan reading one record per cycle, then S_WAIT,
// S_STATRD, S_STATWR, S_FETCH, S_OUT and the output register lead to o_valid; a null,
// untracked or table-full event goes from S_WAIT straight to S_FETCH. A new transaction
// is taken only from S_IDLE, while a finished result may still wait in the output register.
// Reset: synchronous active low; statistics clear at once, then a clearing pass over every
// record empties the record table while o_stall stays high.
module allocation_tracker_with_category_stats import alt_pkg::*; #(
    parameter int TABLE_ENTRIES  = TableEntries,
    parameter int CATEGORY_COUNT = CategoryCount
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);
    localparam int IdxW = $clog2(TABLE_ENTRIES);
    localparam int CntW = $clog2(TABLE_ENTRIES + 1);

    t_state r_state, n_state;
    t_in_item r_item;
    logic [IdxW-1:0] r_idx, n_idx;
    logic [IdxW-1:0] r_scan_idx;  // index whose read data arrives this cycle
    logic r_rd_live, n_rd_live;
    logic r_hit, n_hit;
    logic [IdxW-1:0] r_hit_idx, n_hit_idx;
    logic r_free_found, n_free_found;
    logic [IdxW-1:0] r_free_idx, n_free_idx;
    logic [SizeW-1:0] r_hit_size, n_hit_size;
    logic [CatW-1:0] r_hit_cat, n_hit_cat;
    logic [CntW-1:0] r_in_use, n_in_use;
    logic [1:0] r_status, n_status;
    logic [CatW-1:0] r_rep, n_rep;
    t_out_item r_out;
    logic r_out_valid;

    logic [AddressBits-1:0] t_rd_addr;
    logic [SizeW-1:0] t_rd_size;
    logic [CatW-1:0] t_rd_cat;
    logic t_rd_valid;
    logic tw_en, tw_valid;
    logic [IdxW-1:0] tw_idx;
    logic tbl_ready;
    t_stats s_cat, s_sum, s_cat_new, s_sum_new;
    logic s_wr;
    logic [AddressBits-1:0] w_addr;
    logic [CatW-1:0] w_cat;
    logic take, out_free;

    assign w_addr   = r_item.address;
    assign w_cat    = ({1'b0, r_item.category} >= (CatW+1)'(CATEGORY_COUNT)) ? '0
                                                                          : r_item.category;
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_state != S_IDLE) || !tbl_ready;
    assign take     = i_valid && !o_stall;

    alt_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_table (
        .i_clk, .i_rst_n, .o_ready(tbl_ready),
        .i_rd_idx(r_idx), .o_rd_addr(t_rd_addr), .o_rd_size(t_rd_size),
        .o_rd_cat(t_rd_cat), .o_rd_valid(t_rd_valid),
        .i_wr_en(tw_en), .i_wr_idx(tw_idx), .i_wr_valid(tw_valid),
        .i_wr_addr(w_addr), .i_wr_size(r_item.size_bytes), .i_wr_cat(w_cat)
    );

    alt_stats #(.CATEGORY_COUNT(CATEGORY_COUNT)) u_stats (
        .i_clk, .i_rst_n,
        .i_rd_cat(r_rep), .o_rd_cat(s_cat), .o_sum(s_sum),
        .i_wr_en(s_wr), .i_wr_cat(r_rep),
        .i_wr_cat_stats(s_cat_new), .i_wr_sum(s_sum_new)
    );

    always_comb begin
        if (r_item.func) begin
            s_cat_new = stats_free(s_cat, r_hit_size);
            s_sum_new = stats_free(s_sum, r_hit_size);
        end else begin
            s_cat_new = stats_alloc(s_cat, r_item.size_bytes);
            s_sum_new = stats_alloc(s_sum, r_item.size_bytes);
        end
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_rd_live    = 1'b0;
        n_hit        = r_hit;
        n_hit_idx    = r_hit_idx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_hit_size   = r_hit_size;
        n_hit_cat    = r_hit_cat;
        n_in_use     = r_in_use;
        n_status     = r_status;
        n_rep        = r_rep;
        tw_en        = 1'b0;
        tw_idx       = r_hit_idx;
        tw_valid     = 1'b0;
        s_wr         = 1'b0;
        // Compare the entry whose read data is now present; the last one lands in S_WAIT.
        if (r_rd_live) begin
            if (t_rd_valid && t_rd_addr == w_addr && !r_hit) begin
                n_hit      = 1'b1;
                n_hit_idx  = r_scan_idx;
                n_hit_size = t_rd_size;
                n_hit_cat  = t_rd_cat;
            end
            if (!t_rd_valid && !r_free_found) begin
                n_free_found = 1'b1;
                n_free_idx   = r_scan_idx;
            end
        end
        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    n_state      = S_SCAN;
                    n_idx        = '0;
                    n_hit        = 1'b0;
                    n_free_found = 1'b0;
                end
            end
            S_SCAN: begin
                // Issue reads; compare results as they return.
                n_rd_live = 1'b1;
                if (r_idx == IdxW'(TABLE_ENTRIES - 1)) begin
                    n_state = S_WAIT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_WAIT: begin
                n_status = StOk;
                if (!r_item.func) begin
                    n_rep = w_cat;
                end else begin
                    n_rep = '0;
                end
                if (w_addr == '0) begin
                    n_status = StNull;
                    n_state  = S_FETCH;
                end else if (r_item.func) begin
                    if (!n_hit) begin
                        n_status = StUntracked;
                        n_state  = S_FETCH;
                    end else begin
                        n_rep   = ({1'b0, n_hit_cat} >= (CatW+1)'(CATEGORY_COUNT)) ? '0
                                                                                  : n_hit_cat;
                        n_state = S_STATRD;
                    end
                end else if (!n_hit && !n_free_found) begin
                    n_status = StFull;
                    n_state  = S_FETCH;
                end else begin
                    n_state = S_STATRD;
                end
            end
            S_STATRD: n_state = S_STATWR;
            S_STATWR: begin
                s_wr  = 1'b1;
                tw_en = 1'b1;
                if (r_item.func) begin
                    tw_idx   = r_hit_idx;
                    tw_valid = 1'b0;
                    if (r_in_use != '0) begin
                        n_in_use = r_in_use - 1'b1;
                    end
                end else begin
                    tw_valid = 1'b1;
                    tw_idx   = r_hit ? r_hit_idx : r_free_idx;
                    if (!r_hit) begin
                        n_in_use = r_in_use + 1'b1;
                    end
                end
                n_state = S_FETCH;
            end
            // Reread the reported category after any write has landed.
            S_FETCH: n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_rd_live    <= 1'b0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_in_use     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_rd_live    <= n_rd_live;
            r_hit        <= n_hit;
            r_free_found <= n_free_found;
            r_in_use     <= n_in_use;
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= i_data;
        end
        r_scan_idx <= r_idx;
        r_hit_idx  <= n_hit_idx;
        r_free_idx <= n_free_idx;
        r_hit_size <= n_hit_size;
        r_hit_cat  <= n_hit_cat;
        r_status   <= n_status;
        r_rep      <= n_rep;
        if (r_state == S_OUT && out_free) begin
            // Stats memory reread of r_rep reflects the write made in S_STATWR.
            r_out.status          <= r_status;
            r_out.category_out    <= r_rep;
            r_out.cat_live_bytes  <= s_cat.live_bytes;
            r_out.cat_live_count  <= s_cat.live_count;
            r_out.cat_total_bytes <= s_cat.total_bytes;
            r_out.cat_peak_bytes  <= s_cat.peak_bytes;
            r_out.all_live_bytes  <= s_sum.live_bytes;
            r_out.all_live_count  <= s_sum.live_count;
            r_out.all_total_bytes <= s_sum.total_bytes;
            r_out.all_peak_bytes  <= s_sum.peak_bytes;
            r_out.no_leaks        <= (r_in_use == '0);
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;
endmodule
